// ===== design/affine_transform_builder_2d_defines.svh =====
// Assertion macros for the affine transform builder checker.
// Uses no other file.
`ifndef AFFINE_TRANSFORM_BUILDER_2D_DEFINES_SVH
`define AFFINE_TRANSFORM_BUILDER_2D_DEFINES_SVH
// Assert that a condition implies a consequence in the next cycle.
`define ATB_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
// Assert that a condition holds at every edge out of reset.
`define ATB_ASSERT_ALWAYS(label, clk, rst_n, a) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a)) \
		else $error("assertion failed");
`endif

// ===== design/atb_pkg.sv =====
// Package for the affine transform builder: widths, CORDIC constants, atan table.
// Depends on nothing.
package atb_pkg;
	localparam int AtanLen = 24;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam int TurnUnits = 23040;

	typedef logic signed [33:0] cval_t;

	typedef struct packed {
		logic        action;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} side_t;

	function automatic logic [31:0] atan_at(input int i);
		logic [31:0] t [AtanLen];
		t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
			32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
			32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
			32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
			32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
		return t[i];
	endfunction
endpackage

// ===== design/atb_cordic_cell.sv =====
// One CORDIC micro-rotation cell, registered; carries side data along.
// Depends on atb_pkg.
module atb_cordic_cell import atb_pkg::*; #(
	parameter int Shift = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vin,
	input  cval_t       xin,
	input  cval_t       yin,
	input  logic signed [33:0] zin,
	input  logic        nin,
	input  side_t       sin,
	output logic        vout,
	output cval_t       xout,
	output cval_t       yout,
	output logic signed [33:0] zout,
	output logic        nout,
	output side_t       sout
);
	cval_t xs, ys;
	logic signed [33:0] at;
	assign xs = xin >>> Shift;
	assign ys = yin >>> Shift;
	assign at = $signed({2'b00, atan_at(Shift)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (!zin[33]) begin
			xout <= xin - ys; yout <= yin + xs; zout <= zin - at;
		end else begin
			xout <= xin + ys; yout <= yin - xs; zout <= zin + at;
		end
		nout <= nin;
		sout <= sin;
	end
endmodule

// ===== design/affine_transform_builder_2d.sv =====
// Affine transform builder: angle, scales and position in, 2D affine matrix out.
// Path: stages 1-2, N = min(TRIG_ITERATIONS, 24) cells, stages 4-6, output stage.
// Throughput: one item per cycle; busy stays low, the result strobe cannot stall.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
// Depends on atb_pkg and atb_cordic_cell.
module affine_transform_builder_2d import atb_pkg::*; #(
	parameter int TRIG_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic signed [15:0] angle,
	input  logic signed [15:0] scale_x,
	input  logic signed [15:0] scale_y,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic        done,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22,
	output logic signed [47:0] dx,
	output logic signed [47:0] dy
);
	localparam int N = (TRIG_ITERATIONS < AtanLen) ? TRIG_ITERATIONS : AtanLen;
	// Reciprocal of 23040 for the angle reduction: floor(2^40/23040)+1.
	localparam logic [26:0] Recip = 27'((64'd1 << 40) / 64'd23040 + 64'd1);

	assign busy = 1'b0;

	// Stage 1: reduce angle into [0, 23040). Angle+2*23040 is nonnegative.
	logic v_s1;
	logic [16:0] r_s1;
	side_t d_s1;
	logic [16:0] apos;
	logic [17:0] q;
	logic [16:0] rr;
	always_comb begin
		apos = 17'($signed({angle[15], angle}) + 17'sd46080);
		q = 18'((45'(apos) * 45'(Recip)) >> 40);
		rr = 17'(apos - 17'(q) * 17'(TurnUnits));
		if (rr >= 17'(TurnUnits)) rr = rr - 17'(TurnUnits);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		r_s1 <= rr;
		d_s1 <= '{action, scale_x, scale_y, pos_x, pos_y};
	end

	// Stage 2: theta = floor((r*2^32 + 11520)/23040) = floor((r*2^23 + 22)/45).
	// Split r = 45*a + b: theta = a*2^23 + floor((b*2^23 + 22)/45), the
	// second term from a 45-entry constant table.
	logic v_s2;
	logic [31:0] th_s2;
	side_t d_s2;
	logic [31:0] frac_tab [45];
	logic [31:0] ra_prod;
	logic [8:0] ra;
	logic [5:0] rb;
	logic [31:0] tq;
	for (genvar k = 0; k < 45; k++) begin : g_frac
		assign frac_tab[k] = 32'(((64'(k) << 23) + 64'd22) / 64'd45);
	end
	always_comb begin
		// a = floor(r/45) by reciprocal 2^20/45 rounded up; exact for r < 23040
		ra_prod = 32'(r_s1) * 32'd23302;
		ra = 9'(ra_prod >> 20);
		rb = 6'(r_s1 - 17'(ra) * 17'd45);
		tq = {ra, 23'd0} + frac_tab[rb];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		th_s2 <= tq;
		d_s2 <= d_s1;
	end

	// Stage 3: fold the phase into +-90 degrees.
	logic signed [33:0] z0;
	logic n0;
	always_comb begin
		z0 = 34'($signed(th_s2));
		n0 = 1'b0;
		if (z0 > 34'sd1073741824) begin
			z0 = z0 - 34'sd2147483648; n0 = 1'b1;
		end else if (z0 < -34'sd1073741824) begin
			z0 = z0 + 34'sd2147483648; n0 = 1'b1;
		end
	end

	// CORDIC chain of N cells.
	logic v_c [N+1];
	cval_t x_c [N+1];
	cval_t y_c [N+1];
	logic signed [33:0] z_c [N+1];
	logic n_c [N+1];
	side_t d_c [N+1];
	assign v_c[0] = v_s2;
	assign x_c[0] = CordicGain;
	assign y_c[0] = '0;
	assign z_c[0] = z0;
	assign n_c[0] = n0;
	assign d_c[0] = d_s2;
	for (genvar i = 0; i < N; i++) begin : g_cell
		atb_cordic_cell #(.Shift(i)) u_cell (
			.clk, .arst_n,
			.vin(v_c[i]), .xin(x_c[i]), .yin(y_c[i]), .zin(z_c[i]),
			.nin(n_c[i]), .sin(d_c[i]),
			.vout(v_c[i+1]), .xout(x_c[i+1]), .yout(y_c[i+1]), .zout(z_c[i+1]),
			.nout(n_c[i+1]), .sout(d_c[i+1])
		);
	end

	// Stage 4: round to Q16 and apply the quadrant negation.
	logic v_s4;
	logic signed [19:0] c_s4, s_s4;
	side_t d_s4;
	cval_t xr, yr;
	assign xr = (x_c[N] + 34'sd8192) >>> 14;
	assign yr = (y_c[N] + 34'sd8192) >>> 14;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_c[N];
	end
	always_ff @(posedge clk) begin
		c_s4 <= n_c[N] ? -20'(xr) : 20'(xr);
		s_s4 <= n_c[N] ? -20'(yr) : 20'(yr);
		d_s4 <= d_c[N];
	end

	// Stage 5: scale*trig products and the full pivot rotation products.
	logic v_s5;
	logic signed [51:0] pxc_s5, pys_s5, pxs_s5, pyc_s5;
	logic signed [35:0] a11_s5, a12_s5, a21_s5, a22_s5;
	side_t d_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end
	always_ff @(posedge clk) begin
		a11_s5 <= d_s4.sx * c_s4;
		a12_s5 <= (d_s4.action ? d_s4.sy : d_s4.sx) * s_s4;
		a21_s5 <= (d_s4.action ? d_s4.sx : d_s4.sy) * s_s4;
		a22_s5 <= d_s4.sy * c_s4;
		pxc_s5 <= d_s4.px * c_s4;
		pys_s5 <= d_s4.py * s_s4;
		pxs_s5 <= d_s4.px * s_s4;
		pyc_s5 <= d_s4.py * c_s4;
		d_s5 <= d_s4;
	end

	// Stage 6: exact u, v from full products (rounding of the sum, not terms).
	logic v_s6;
	logic signed [35:0] a11_s6, a12_s6, a21_s6, a22_s6;
	logic signed [52:0] u_s6, w_s6;
	side_t d_s6;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		a11_s6 <= a11_s5; a12_s6 <= a12_s5; a21_s6 <= a21_s5; a22_s6 <= a22_s5;
		u_s6 <= (53'(pxc_s5) - 53'(pys_s5) + 53'sd32768) >>> 16;
		w_s6 <= (53'(pxs_s5) + 53'(pyc_s5) + 53'sd32768) >>> 16;
		d_s6 <= d_s5;
	end

	// Output stage: round matrix terms, form and saturate the translation.
	logic signed [69:0] tx, ty;
	always_comb begin
		tx = 70'(d_s6.px) - ((70'(d_s6.sx) * 70'(u_s6) + 70'sd128) >>> 8);
		ty = 70'(d_s6.py) - ((70'(d_s6.sy) * 70'(w_s6) + 70'sd128) >>> 8);
		if (!d_s6.action) begin
			tx = 70'(d_s6.px); ty = 70'(d_s6.py);
		end
	end
	function automatic logic signed [47:0] sat48(input logic signed [69:0] v);
		if (v > 70'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
		if (v < -70'sh800000000000) return 48'sh800000000000;
		return 48'(v);
	endfunction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= v_s6;
	end
	always_ff @(posedge clk) begin
		m11 <= 32'((a11_s6 + 36'sd128) >>> 8);
		m12 <= 32'((a12_s6 + 36'sd128) >>> 8);
		m21 <= -32'((a21_s6 + 36'sd128) >>> 8);
		m22 <= 32'((a22_s6 + 36'sd128) >>> 8);
		dx <= sat48(tx);
		dy <= sat48(ty);
	end
endmodule

// ===== design/atb_checker.sv =====
// Port-level checker for the affine transform builder, bound to the top level.
// Depends on affine_transform_builder_2d_defines.svh.
`include "affine_transform_builder_2d_defines.svh"
module atb_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	`ATB_ASSERT_ALWAYS(a_never_busy, clk, arst_n, !busy)
	`ATB_ASSERT_NEXT(a_no_done_idle, clk, arst_n, !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start ##1 !start, !done)
	`ATB_ASSERT_ALWAYS(a_done_known, clk, arst_n, !$isunknown(done))
endmodule

bind affine_transform_builder_2d atb_checker u_atb_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done)
);

// ===== tb/testbench.sv =====
// Testbench for affine_transform_builder_2d: drives angle/scale/position items and
// checks each matrix against a CORDIC-based predictor kept in this file.
// Depends on atb_pkg (atan table) and the block under test.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TrigIter = 16;
	localparam int LatencyCycles = 6 + TrigIter;
	localparam logic ActScaleRotTrans = 1'b0;
	localparam logic ActPivot = 1'b1;

	typedef struct {
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
		logic signed [47:0] dx;
		logic signed [47:0] dy;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic action = 1'b0;
	logic signed [15:0] angle = '0;
	logic signed [15:0] scale_x = '0;
	logic signed [15:0] scale_y = '0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic done;
	logic signed [31:0] m11, m12, m21, m22;
	logic signed [47:0] dx, dy;

	matrix_t pending_matrices[$];
	int error_count = 0;
	int items_sent = 0;
	int matrices_seen = 0;
	int pivot_items = 0;
	bit gaps_on = 1'b1;

	affine_transform_builder_2d #(.TRIG_ITERATIONS(TrigIter)) u_dut (.*);

	always #5 clk = ~clk;

	// Arithmetic shift right, round half up (the block's one rounding rule).
	function automatic longint round_shift(input longint v, input int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	// Q16 cosine and sine from a binary-angle CORDIC rotator.
	function automatic void trig_q16(input longint ang, output longint c, output longint s);
		longint r, z, x, y, xs, ys;
		longint unsigned theta;
		bit flip;
		r = ang % 23040;
		if (r < 0)
			r += 23040;
		theta = ((longint'(r) << 32) + 11520) / 23040;
		theta &= 64'hFFFF_FFFF;
		z = longint'(theta);
		flip = 1'b0;
		if (z >= (longint'(1) << 31))
			z -= longint'(1) << 32;
		// fold the back half-plane onto the front one
		if (z > (longint'(1) << 30)) begin
			z -= longint'(1) << 31;
			flip = 1'b1;
		end else if (z < -(longint'(1) << 30)) begin
			z += longint'(1) << 31;
			flip = 1'b1;
		end
		x = 652032874;
		y = 0;
		for (int i = 0; i < (TrigIter < 24 ? TrigIter : 24); i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(atb_pkg::atan_at(i));
			end else begin
				x += ys; y -= xs; z += longint'(atb_pkg::atan_at(i));
			end
		end
		c = round_shift(x, 14);
		s = round_shift(y, 14);
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic longint clamp48(input longint v);
		longint hi, lo;
		hi = (longint'(1) << 47) - 1;
		lo = -(longint'(1) << 47);
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic matrix_t build_matrix(input logic act, input logic signed [15:0] ang,
			input logic signed [15:0] sx16, input logic signed [15:0] sy16,
			input logic signed [31:0] px32, input logic signed [31:0] py32);
		matrix_t m;
		longint c, s, sx, sy, px, py, u, v, tx, ty;
		trig_q16(longint'(ang), c, s);
		sx = sx16; sy = sy16; px = px32; py = py32;
		if (act == ActScaleRotTrans) begin
			m.m11 = 32'(round_shift(sx * c, 8));
			m.m12 = 32'(round_shift(sx * s, 8));
			m.m21 = 32'(-round_shift(sy * s, 8));
			m.m22 = 32'(round_shift(sy * c, 8));
			tx = px;
			ty = py;
		end else begin
			u = round_shift(px * c - py * s, 16);
			v = round_shift(px * s + py * c, 16);
			m.m11 = 32'(round_shift(c * sx, 8));
			m.m12 = 32'(round_shift(s * sy, 8));
			m.m21 = 32'(-round_shift(s * sx, 8));
			m.m22 = 32'(round_shift(c * sy, 8));
			tx = px - round_shift(sx * u, 8);
			ty = py - round_shift(sy * v, 8);
		end
		m.dx = 48'(clamp48(tx));
		m.dy = 48'(clamp48(ty));
		return m;
	endfunction

	// Send one item: drive at the falling edge, hold until accepted at a rising edge.
	task automatic send_item(input logic act, input logic signed [15:0] ang,
			input logic signed [15:0] sx, input logic signed [15:0] sy,
			input logic signed [31:0] px, input logic signed [31:0] py);
		int gap;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		action <= act;
		angle <= ang;
		scale_x <= sx;
		scale_y <= sy;
		pos_x <= px;
		pos_y <= py;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_matrices.push_back(build_matrix(act, ang, sx, sy, px, py));
		items_sent++;
		if (act == ActPivot)
			pivot_items++;
		@(negedge clk);
	endtask

	task automatic idle_line();
		start <= 1'b0;
	endtask

	// Compare each strobed matrix against the oldest prediction.
	always @(posedge clk) begin
		matrix_t e;
		if (arst_n && done) begin
			matrices_seen++;
			if (pending_matrices.size() == 0) begin
				$display("%0t: unexpected result m11=%h", $time, m11);
				error_count++;
			end else begin
				e = pending_matrices.pop_front();
				if (m11 !== e.m11) begin
					$display("%0t: m11 expected %h actual %h", $time, e.m11, m11);
					error_count++;
				end
				if (m12 !== e.m12) begin
					$display("%0t: m12 expected %h actual %h", $time, e.m12, m12);
					error_count++;
				end
				if (m21 !== e.m21) begin
					$display("%0t: m21 expected %h actual %h", $time, e.m21, m21);
					error_count++;
				end
				if (m22 !== e.m22) begin
					$display("%0t: m22 expected %h actual %h", $time, e.m22, m22);
					error_count++;
				end
				if (dx !== e.dx) begin
					$display("%0t: dx expected %h actual %h", $time, e.dx, dx);
					error_count++;
				end
				if (dy !== e.dy) begin
					$display("%0t: dy expected %h actual %h", $time, e.dy, dy);
					error_count++;
				end
			end
		end
	end

	// Extremes of every field, both actions, wrap and mirror.
	task automatic test_directed();
		send_item(ActScaleRotTrans, 16'sd0, 16'sd256, 16'sd256, 32'sd0, 32'sd0);
		send_item(ActPivot, 16'sd0, 16'sd256, 16'sd256, 32'sd65536, -32'sd65536);
		send_item(ActScaleRotTrans, 16'sd5760, 16'sd256, 16'sd512, 32'sd1, 32'sd2);
		send_item(ActPivot, 16'sd11520, 16'sd256, 16'sd256, 32'sd100000, 32'sd300);
		send_item(ActScaleRotTrans, 16'sd17280, -16'sd256, 16'sd256, 32'sd7, -32'sd7);
		send_item(ActPivot, 16'sd23040, 16'sd256, 16'sd256, 32'sd12345, 32'sd54321);
		send_item(ActScaleRotTrans, 16'sd32767, 16'sd32767, 16'sd32767, 32'h7FFFFFFF,
			32'h7FFFFFFF);
		send_item(ActScaleRotTrans, -16'sd32768, -16'sd32768, -16'sd32768, 32'h80000000,
			32'h80000000);
		send_item(ActPivot, 16'sd32767, 16'sd32767, -16'sd32768, 32'h7FFFFFFF, 32'h80000000);
		send_item(ActPivot, -16'sd32768, -16'sd32768, -16'sd32768, 32'h80000000,
			32'h80000000);
		send_item(ActPivot, 16'sd0, -16'sd32768, -16'sd32768, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_item(ActPivot, 16'sd11520, 16'sd32767, 16'sd32767, 32'h80000000, 32'h7FFFFFFF);
		send_item(ActPivot, -16'sd5760, -16'sd256, 16'sd128, -32'sd65536, 32'sd65536);
		send_item(ActPivot, 16'sd2880, 16'sd0, 16'sd0, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(ActScaleRotTrans, -16'sd1, 16'sd1, -16'sd1, 32'sd0, 32'hFFFFFFFF);
		send_item(ActPivot, 16'sd5761, 16'sd256, 16'sd256, 32'h40000000, 32'hC0000000);
	endtask

	// Random items: mostly moderate values, with a share of full-range fields.
	task automatic test_random(input int count);
		logic signed [15:0] sx, sy;
		logic signed [31:0] px, py;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 3) == 0) begin
				sx = 16'($urandom);
				sy = 16'($urandom);
				px = 32'($urandom);
				py = 32'($urandom);
			end else begin
				sx = 16'($signed($urandom_range(0, 1024)) - 512);
				sy = 16'($signed($urandom_range(0, 1024)) - 512);
				px = 32'($urandom) >>> $urandom_range(0, 16);
				py = 32'($urandom) >>> $urandom_range(0, 16);
			end
			send_item(1'($urandom), 16'($urandom), sx, sy, px, py);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(1500);
		// back to back for the tail of the run
		gaps_on = 1'b0;
		test_random(300);
		idle_line();
		while (pending_matrices.size() != 0)
			@(posedge clk);
		repeat (LatencyCycles + 4) @(posedge clk);
		$display("Sent %0d items (%0d pivot form), checked %0d matrices.",
			items_sent, pivot_items, matrices_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results outstanding", pending_matrices.size());
		$display("DONE: errors detected");
		$finish;
	end
endmodule
